[hw/rtl/rrcb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rrcb_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 11;

  // Fixed register and field widths
  localparam int DIM_BITS  = 11;
  localparam int RAD_BITS  = 10;
  localparam int GREY_BITS = 8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RECT_WIDTH       = 3'd0,
    CFG_RECT_HEIGHT      = 3'd1,
    CFG_CORNER_RADIUS    = 3'd2,
    CFG_BORDER_THICKNESS = 3'd3,
    CFG_INK_GREY         = 3'd4,
    CFG_FILL_MODE        = 3'd5
  } cfg_idx_e;

  // Per-pixel data that rides alongside the distance pipeline
  typedef struct packed {
    logic                 corner;
    logic                 flat_border;
    logic [GREY_BITS-1:0] dst;
  } pix_side_t;

endpackage

`default_nettype wire

[hw/rtl/rounded_rect_coverage_blend_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Antialiased rounded-rectangle pixel shader with grey blending.
// Pixel channel: col_i, row_i and dest_grey_i are taken at every rising edge at
// which start_i is high and busy_o is low. busy_o is held low: a new pixel may
// be issued on every clock, one pixel per cycle sustained.
// Result channel: result_valid_o is high for exactly one cycle with
// write_enable_o and new_grey_o; results come out in issue order, one per pixel.
// Pipeline: the digit-by-digit square root retires one root bit per pipeline
// stage; it sits behind three front stages (corner offsets, squares, radicand)
// and ahead of four back stages (distance, coverage, blend products, divide by
// 255).
// Configuration: cfg_we_i writes register cfg_idx_i with cfg_data_i at the
// edge; write only while no pixel is in flight.
// Reset clears the configuration registers and the pipeline valid bits; nothing in flight
// survives it. The receiver has no back-pressure, so the pipeline never stalls.
module rounded_rect_coverage_blend_unit
  import rrcb_pkg::*;
#(
  parameter int COORD_BITS = 11
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic [COORD_BITS-1:0]    col_i,
  input  wire logic [COORD_BITS-1:0]    row_i,
  input  wire logic [GREY_BITS-1:0]     dest_grey_i,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output logic                          result_valid_o,
  output logic                          write_enable_o,
  output logic [GREY_BITS-1:0]          new_grey_o
);

  // Derived widths
  localparam int DX_BITS  = ((COORD_BITS > RAD_BITS) ? COORD_BITS : RAD_BITS) + 1;
  localparam int W_BITS   = (COORD_BITS < DIM_BITS) ? COORD_BITS : DIM_BITS;
  localparam int SQ_BITS  = 2 * DX_BITS + 1;
  localparam int ROOT_BITS = DX_BITS + 9;
  localparam int RAD_W    = 2 * ROOT_BITS;
  localparam int REM_W    = ROOT_BITS + 2;
  localparam int D8_BITS  = ROOT_BITS + 2;
  localparam int LATENCY  = ROOT_BITS + 7;

  localparam logic signed [D8_BITS-1:0] D8_HALF  = D8_BITS'(128);
  localparam logic signed [D8_BITS-1:0] D8_NHALF = D8_BITS'(-128);

  // ------------------------------------------------------------------
  // Configuration registers
  logic [DIM_BITS-1:0]  rect_width_q, rect_height_q;
  logic [RAD_BITS-1:0]  corner_radius_q, border_thickness_q;
  logic [GREY_BITS-1:0] ink_grey_q;
  logic                 fill_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_width_q       <= '0;
      rect_height_q      <= '0;
      corner_radius_q    <= '0;
      border_thickness_q <= '0;
      ink_grey_q         <= '0;
      fill_mode_q        <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RECT_WIDTH:       rect_width_q       <= cfg_data_i;
        CFG_RECT_HEIGHT:      rect_height_q      <= cfg_data_i;
        CFG_CORNER_RADIUS:    corner_radius_q    <= cfg_data_i[RAD_BITS-1:0];
        CFG_BORDER_THICKNESS: border_thickness_q <= cfg_data_i[RAD_BITS-1:0];
        CFG_INK_GREY:         ink_grey_q         <= cfg_data_i[GREY_BITS-1:0];
        CFG_FILL_MODE:        fill_mode_q        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Always ready
  assign busy_o = 1'b0;

  // ------------------------------------------------------------------
  // Stage 1: corner offsets and straight border test

  // Offset into the corner circle along one axis, 0 when outside a corner band
  function automatic logic [DX_BITS-1:0] axis_off(input logic [COORD_BITS-1:0] p,
                                                 input logic [W_BITS-1:0]     len,
                                                 input logic [RAD_BITS-1:0]   r);
    logic [DX_BITS-1:0] pr1;
    logic [DX_BITS-1:0] res;
    pr1 = DX_BITS'(p) + DX_BITS'(r) + DX_BITS'(1);
    if (DX_BITS'(p) < DX_BITS'(r)) begin
      res = DX_BITS'(r) - DX_BITS'(p);
    end else if (pr1 > DX_BITS'(len)) begin
      res = pr1 - DX_BITS'(len);
    end else begin
      res = '0;
    end
    return res;
  endfunction

  logic [W_BITS-1:0]  w_eff, h_eff;
  logic [DX_BITS-1:0] dx_d, dy_d;
  logic               flat_d;
  pix_side_t          s1_side_d;

  assign w_eff = rect_width_q[W_BITS-1:0];
  assign h_eff = rect_height_q[W_BITS-1:0];

  always_comb begin
    dx_d   = axis_off(col_i, w_eff, corner_radius_q);
    dy_d   = axis_off(row_i, h_eff, corner_radius_q);
    flat_d = (DX_BITS'(col_i) < DX_BITS'(border_thickness_q)) ||
             (DX_BITS'(row_i) < DX_BITS'(border_thickness_q)) ||
             ((DX_BITS'(col_i) + DX_BITS'(border_thickness_q)) >= DX_BITS'(w_eff)) ||
             ((DX_BITS'(row_i) + DX_BITS'(border_thickness_q)) >= DX_BITS'(h_eff));
    s1_side_d.corner      = (dx_d != '0) && (dy_d != '0);
    s1_side_d.flat_border = flat_d;
    s1_side_d.dst         = dest_grey_i;
  end

  logic               s1_valid_q;
  logic [DX_BITS-1:0] s1_dx_q, s1_dy_q;
  pix_side_t          s1_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_dx_q   <= dx_d;
    s1_dy_q   <= dy_d;
    s1_side_q <= s1_side_d;
  end

  // ------------------------------------------------------------------
  // Stage 2: squares of the offsets
  logic                   s2_valid_q;
  logic [2*DX_BITS-1:0]   s2_sqx_q, s2_sqy_q;
  pix_side_t              s2_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_sqx_q  <= (2*DX_BITS)'(s1_dx_q) * (2*DX_BITS)'(s1_dx_q);
    s2_sqy_q  <= (2*DX_BITS)'(s1_dy_q) * (2*DX_BITS)'(s1_dy_q);
    s2_side_q <= s1_side_q;
  end

  // ------------------------------------------------------------------
  // Stage 3: radicand (dx^2 + dy^2) << 16, then one root bit per stage
  logic [SQ_BITS-1:0] sq_sum_d;
  logic [RAD_W-1:0]   rad_q  [ROOT_BITS+1];
  logic [REM_W-1:0]   rem_q  [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] root_q [ROOT_BITS+1];
  pix_side_t          side_q [ROOT_BITS+1];
  logic               sv_q   [ROOT_BITS+1];

  assign sq_sum_d = SQ_BITS'(s2_sqx_q) + SQ_BITS'(s2_sqy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else begin
      sv_q[0] <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q[0]  <= {1'b0, sq_sum_d, 16'h0000};
    rem_q[0]  <= '0;
    root_q[0] <= '0;
    side_q[0] <= s2_side_q;
  end

  // Restoring square root, one result bit per stage
  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    assign rem_sh = {rem_q[k][ROOT_BITS-1:0], rad_q[k][RAD_W-1 -: 2]};
    assign trial  = {root_q[k], 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k+1] <= 1'b0;
      end else begin
        sv_q[k+1] <= sv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[k+1]  <= rad_q[k] << 2;
      side_q[k+1] <= side_q[k];
      if (rem_sh >= trial) begin
        rem_q[k+1]  <= rem_sh - trial;
        root_q[k+1] <= {root_q[k][ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_q[k+1]  <= rem_sh;
        root_q[k+1] <= {root_q[k][ROOT_BITS-2:0], 1'b0};
      end
    end
  end

  // ------------------------------------------------------------------
  // Distance stage: d8 = radius * 256 - root
  logic                       d_valid_q;
  logic signed [D8_BITS-1:0]  d_d8_q;
  pix_side_t                  d_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else begin
      d_valid_q <= sv_q[ROOT_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    d_d8_q   <= $signed({{(D8_BITS-18){1'b0}}, corner_radius_q, 8'h00}) -
                $signed({2'b00, root_q[ROOT_BITS]});
    d_side_q <= side_q[ROOT_BITS];
  end

  // ------------------------------------------------------------------
  // Coverage stage: write decision and blend weight
  logic signed [D8_BITS-1:0] thick_thr;
  logic                      inside_d, outside_d, border_d, e1_we_d;
  logic [GREY_BITS-1:0]      edge_d, alpha_d;

  always_comb begin
    thick_thr = $signed({{(D8_BITS-18){1'b0}}, border_thickness_q, 8'h80});
    inside_d  = !d_side_q.corner || (d_d8_q > D8_HALF);
    outside_d = d_side_q.corner && (d_d8_q <= D8_NHALF);
    // floor((d8 + 128) * 255 / 256) reduces to d8 + 127 across the edge band
    if (d_side_q.corner && (d_d8_q > D8_NHALF) && (d_d8_q < D8_HALF)) begin
      edge_d = d_d8_q[GREY_BITS-1:0] + 8'd127;
    end else begin
      edge_d = '0;
    end
    border_d = d_side_q.flat_border || (d_side_q.corner && (d_d8_q < thick_thr));
    e1_we_d  = !outside_d && (inside_d || (edge_d != '0)) && (fill_mode_q || border_d);
    // Full weight gives the ink value itself
    alpha_d  = (edge_d != '0) ? edge_d : 8'hFF;
  end

  logic                 e1_valid_q, e1_we_q;
  logic [GREY_BITS-1:0] e1_alpha_q, e1_dst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_valid_q <= 1'b0;
    end else begin
      e1_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e1_we_q    <= e1_we_d;
    e1_alpha_q <= alpha_d;
    e1_dst_q   <= d_side_q.dst;
  end

  // ------------------------------------------------------------------
  // Blend products: ink * a + dst * (255 - a)
  logic                 e2_valid_q, e2_we_q;
  logic [15:0]          e2_sum_q;
  logic [GREY_BITS-1:0] e2_dst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e2_valid_q <= 1'b0;
    end else begin
      e2_valid_q <= e1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e2_sum_q <= 16'(ink_grey_q) * 16'(e1_alpha_q) +
                16'(e1_dst_q) * 16'(8'hFF - e1_alpha_q);
    e2_we_q  <= e1_we_q;
    e2_dst_q <= e1_dst_q;
  end

  // ------------------------------------------------------------------
  // Divide by 255 (exact for blend sums up to 255 * 255) and output register
  logic [16:0]          div_tmp;
  logic [GREY_BITS-1:0] grey_d;

  always_comb begin
    div_tmp = 17'(e2_sum_q) + 17'd1 + 17'(e2_sum_q[15:8]);
    grey_d  = e2_we_q ? div_tmp[15:8] : e2_dst_q;
  end

  logic                 out_valid_q, out_we_q;
  logic [GREY_BITS-1:0] out_grey_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= e2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_we_q   <= e2_we_q;
    out_grey_q <= grey_d;
  end

  assign result_valid_o = out_valid_q;
  assign write_enable_o = out_we_q;
  assign new_grey_o     = out_grey_q;

  // ------------------------------------------------------------------
  // Assertions

  // Every accepted pixel yields one result
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(LATENCY) result_valid_o)
    else $error("accepted pixel produced no result");

  // No result appears without a matching accepted pixel
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without an accepted pixel");

  // An unwritten pixel passes the destination grey through
  a_pass_dst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !write_enable_o) |-> (new_grey_o == $past(e2_dst_q)))
    else $error("unwritten pixel altered grey value");

  // A partial weight can only come from the edge band of a corner
  a_edge_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e1_valid_q && (e1_alpha_q != 8'hFF)) |-> $past(d_valid_q && d_side_q.corner))
    else $error("partial coverage outside a corner");

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import rrcb_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int RESET_CYCLES = 10;
  localparam int PIPE_SLACK = 40;        // pipeline depth is 28 at 11-bit coordinates
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 14;
  localparam int PIXELS_PER_PHASE = 135;
  localparam int MAX_REPORTS = 10;
  localparam int COORD_MAX = (1 << DIM_BITS) - 1;

  typedef struct {
    logic [DIM_BITS-1:0]  col;
    logic [DIM_BITS-1:0]  row;
    logic [GREY_BITS-1:0] dest;
  } pixel_t;

  typedef struct {
    logic                 we;
    logic [GREY_BITS-1:0] grey;
  } shade_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic [DIM_BITS-1:0]      col_i = '0;
  logic [DIM_BITS-1:0]      row_i = '0;
  logic [GREY_BITS-1:0]     dest_grey_i = '0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;
  logic                     busy_o;
  logic                     result_valid_o;
  logic                     write_enable_o;
  logic [GREY_BITS-1:0]     new_grey_o;

  // Shadow copy of the shape registers
  logic [DIM_BITS-1:0]  shape_w = '0;
  logic [DIM_BITS-1:0]  shape_h = '0;
  logic [RAD_BITS-1:0]  shape_rad = '0;
  logic [RAD_BITS-1:0]  shape_thick = '0;
  logic [GREY_BITS-1:0] shape_ink = '0;
  logic                 shape_fill = 1'b0;

  pixel_t pixel_queue[$];
  shade_t shade_queue[$];
  bit     pixel_taken = 1'b0;
  bit     gaps_on = 1'b1;
  int     gap_left = 0;
  int     fail_count = 0;
  int     cycle_count = 0;

  rounded_rect_coverage_blend_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .col_i          (col_i),
    .row_i          (row_i),
    .dest_grey_i    (dest_grey_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .write_enable_o (write_enable_o),
    .new_grey_o     (new_grey_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Truncated square root, one result bit at a time from the top
  function automatic longint root_floor(longint v);
    longint acc;
    longint trial;
    acc = 0;
    for (int b = 22; b >= 0; b--) begin
      trial = acc | (longint'(1) << b);
      if (trial * trial <= v) acc = trial;
    end
    return acc;
  endfunction

  // Distance into the corner zone along one axis, 0 in the straight part
  function automatic longint corner_offset(longint p, longint len, longint r);
    if (p < r) return r - p;
    if (p >= len - r) return p - (len - r - 1);
    return 0;
  endfunction

  function automatic int unsigned blend_grey(int unsigned ink, int unsigned dst,
                                             int unsigned a);
    return (ink * a + dst * (255 - a)) / 255;
  endfunction

  // Expected write decision and grey for one pixel under the current shape
  function automatic shade_t shade_pixel(pixel_t px);
    longint x, y, w, h, r, t, dx, dy, d8, root;
    bit corner, in_shape, border;
    int unsigned cov;
    shade_t res;
    x = longint'(px.col);
    y = longint'(px.row);
    w = longint'(shape_w);
    h = longint'(shape_h);
    r = longint'(shape_rad);
    t = longint'(shape_thick);
    dx = corner_offset(x, w, r);
    dy = corner_offset(y, h, r);
    corner = (dx != 0) && (dy != 0);
    d8 = 0;
    in_shape = 1'b1;
    cov = 0;
    res.we = 1'b0;
    res.grey = px.dest;
    if (corner) begin
      root = root_floor((dx * dx + dy * dy) << 16);
      d8 = r * 256 - root;
      in_shape = d8 > 128;
      // fully outside the arc: never written
      if (d8 <= -128) return res;
      if (d8 < 128) cov = 32'(((d8 + 128) * 255) >> 8);
    end
    if (shape_fill) begin
      if (in_shape) begin
        res.we = 1'b1;
        res.grey = shape_ink;
      end else if (cov != 0) begin
        res.we = 1'b1;
        res.grey = GREY_BITS'(blend_grey(shape_ink, px.dest, cov));
      end
    end else begin
      border = x < t || y < t || x >= w - t || y >= h - t ||
               (corner && d8 < t * 256 + 128);
      if (border && (in_shape || cov != 0)) begin
        res.we = 1'b1;
        res.grey = GREY_BITS'(blend_grey(shape_ink, px.dest, (cov != 0) ? cov : 255));
      end
    end
    return res;
  endfunction

  // Coordinate biased towards the corner zones and the shape edges
  function automatic logic [DIM_BITS-1:0] near_axis(int len, int r);
    int lo, hi;
    case ($urandom_range(0, 2))
      0: begin
        lo = 0;
        hi = r + 2;
      end
      1: begin
        lo = len - r - 2;
        hi = len + 2;
      end
      default: begin
        lo = 0;
        hi = len + 2;
      end
    endcase
    if (lo < 0) lo = 0;
    if (hi > COORD_MAX) hi = COORD_MAX;
    if (lo > hi) lo = hi;
    return DIM_BITS'($urandom_range(hi, lo));
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    if ($urandom_range(0, 4) == 0) begin
      px.col = DIM_BITS'($urandom_range(0, COORD_MAX));
      px.row = DIM_BITS'($urandom_range(0, COORD_MAX));
    end else begin
      px.col = near_axis(int'(shape_w), int'(shape_rad));
      px.row = near_axis(int'(shape_h), int'(shape_rad));
    end
    case ($urandom_range(0, 7))
      0: px.dest = '0;
      1: px.dest = '1;
      default: px.dest = GREY_BITS'($urandom_range(0, 255));
    endcase
    return px;
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_shape(input int w, input int h, input int r, input int t,
                           input int ink, input int fill);
    write_reg(CFG_RECT_WIDTH, CFG_DATA_BITS'(w));
    write_reg(CFG_RECT_HEIGHT, CFG_DATA_BITS'(h));
    write_reg(CFG_CORNER_RADIUS, CFG_DATA_BITS'(r));
    write_reg(CFG_BORDER_THICKNESS, CFG_DATA_BITS'(t));
    write_reg(CFG_INK_GREY, CFG_DATA_BITS'(ink));
    write_reg(CFG_FILL_MODE, CFG_DATA_BITS'(fill));
  endtask

  // Block until every queued pixel is out and checked, then let the pipe settle
  task automatic drain();
    while (pixel_queue.size() != 0 || start_i || shade_queue.size() != 0)
      @(posedge clk_i);
    repeat (PIPE_SLACK) @(posedge clk_i);
  endtask

  function automatic void push_pixel(int c, int r, int d);
    pixel_t px;
    px.col = DIM_BITS'(c);
    px.row = DIM_BITS'(r);
    px.dest = GREY_BITS'(d);
    pixel_queue.push_back(px);
  endfunction

  // Stimulus: directed shapes, then random shapes with edge-biased pixels
  initial begin
    int rw, rh, rr, rt;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int s = 0; s < 4; s++) begin
      case (s)
        0: set_shape(40, 30, 10, 3, 200, 1);
        1: set_shape(40, 30, 10, 3, 200, 0);
        2: set_shape(16, 12, 0, 2, 90, 0);      // zero radius
        default: set_shape(8, 6, 20, 1, 255, 1); // radius beyond the rectangle
      endcase
      push_pixel(0, 0, 100);
      push_pixel(2, 3, 0);
      push_pixel(3, 2, 255);
      push_pixel(20, 15, 77);
      push_pixel(39, 29, 128);
      push_pixel(COORD_MAX, COORD_MAX, 255);
      drain();
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 0) begin
        set_shape(COORD_MAX, COORD_MAX, 1023, 1023, 255, 1);
      end else if (p == 1) begin
        set_shape(0, 0, 0, 0, 0, 0);
      end else begin
        rw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, COORD_MAX) : $urandom_range(0, 120);
        rh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, COORD_MAX) : $urandom_range(0, 120);
        rr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, COORD_MAX) : $urandom_range(0, 40);
        rt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, COORD_MAX) : $urandom_range(0, 8);
        set_shape(rw, rh, rr, rt, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
      end
      // no gaps in the closing phases, and none in every third phase
      gaps_on = (p < RAND_PHASES - 2) && (p % 3 != 2);
      for (int i = 0; i < PIXELS_PER_PHASE; i++) pixel_queue.push_back(random_pixel());
      drain();
    end

    if (fail_count == 0 && shade_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Pixel driver: holds a transaction until taken, idles in random bursts
  always @(negedge clk_i) begin
    pixel_t px;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!(start_i && !pixel_taken)) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        start_i <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        gap_left = $urandom_range(1, 19) - 1;
        start_i <= 1'b0;
      end else if (pixel_queue.size() != 0) begin
        px = pixel_queue.pop_front();
        start_i <= 1'b1;
        col_i <= px.col;
        row_i <= px.row;
        dest_grey_i <= px.dest;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: register shadow, expectation on acceptance, result check
  always @(posedge clk_i) begin
    pixel_t px;
    shade_t want;
    pixel_taken = rst_ni && start_i && !busy_o;
    if (rst_ni && cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RECT_WIDTH:       shape_w <= cfg_data_i[DIM_BITS-1:0];
        CFG_RECT_HEIGHT:      shape_h <= cfg_data_i[DIM_BITS-1:0];
        CFG_CORNER_RADIUS:    shape_rad <= cfg_data_i[RAD_BITS-1:0];
        CFG_BORDER_THICKNESS: shape_thick <= cfg_data_i[RAD_BITS-1:0];
        CFG_INK_GREY:         shape_ink <= cfg_data_i[GREY_BITS-1:0];
        CFG_FILL_MODE:        shape_fill <= cfg_data_i[0];
        default: ;
      endcase
    end
    if (pixel_taken) begin
      px.col = col_i;
      px.row = row_i;
      px.dest = dest_grey_i;
      shade_queue.push_back(shade_pixel(px));
    end
    if (rst_ni && result_valid_o) begin
      if (shade_queue.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("[%0t] unexpected result: we=%b grey=%0d", $realtime,
                   write_enable_o, new_grey_o);
        fail_count++;
      end else begin
        want = shade_queue.pop_front();
        if (write_enable_o !== want.we || new_grey_o !== want.grey) begin
          if (fail_count < MAX_REPORTS)
            $display("[%0t] mismatch: we exp %b got %b, grey exp %0d got %0d",
                     $realtime, want.we, write_enable_o, want.grey, new_grey_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
